// ===== src/color_similarity_edge_mask_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the color similarity edge mask core
// Shared concurrent check forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COLOR_SIMILARITY_EDGE_MASK_CORE_DEFINES_SVH
`define COLOR_SIMILARITY_EDGE_MASK_CORE_DEFINES_SVH

// same-cycle implication
`define CSEM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csem check failed");

// next-cycle implication
`define CSEM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csem check failed");

`endif

// ===== src/csem_pkg.sv =====
// ----------------------------------------------------------------------------
// csem_pkg
// Types, constants and helpers of the color similarity edge mask core.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;

  localparam int DimW     = 12;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = $clog2(MaxHeight);
  localparam int InRowW   = RowW + 1;
  localparam int ChanW    = 8;
  localparam int CountW   = 4;
  localparam int WinW     = 9;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;
  localparam int LineW    = 2;

  localparam logic [DimW-1:0]  ResetWidth  = DimW'(640);
  localparam logic [DimW-1:0]  ResetHeight = DimW'(480);
  localparam logic [ChanW-1:0] ResetTol    = ChanW'(16);
  localparam logic [CountW-1:0] FullCount  = CountW'(8);

  localparam logic ActPixel = 1'b0;
  localparam logic ActFlush = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 3'd0,
    CfgImageHeight = 3'd1,
    CfgSeedRed     = 3'd2,
    CfgSeedGreen   = 3'd3,
    CfgSeedBlue    = 3'd4,
    CfgTolerance   = 3'd5
  } csem_cfg_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } csem_seed_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } csem_border_t;

  typedef struct packed {
    logic              similar;
    logic              edge_flag;
    logic [CountW-1:0] count;
  } csem_result_t;

  // last valid index of a dimension clamped to [2, lim], so the index lies in [1, lim-1]
  function automatic logic [DimW-1:0] dim_last(input logic [DimW-1:0] v,
                                               input logic [DimW-1:0] lim);
    logic [DimW-1:0] r;
    if (v < DimW'(2)) begin
      r = DimW'(1);
    end else if (v > lim) begin
      r = lim - DimW'(1);
    end else begin
      r = v - DimW'(1);
    end
    return r;
  endfunction

endpackage

// ===== src/csem_line_ram.sv =====
// ----------------------------------------------------------------------------
// csem_line_ram
// Single-clock line memory, one write and one registered read per cycle,
// write-first when both hit the same entry.
// ----------------------------------------------------------------------------
module csem_line_ram #(
  parameter int Depth = 2048,
  parameter int Width = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_q;
  logic [Width-1:0] byp_data_q;
  logic             byp_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q       <= mem[raddr_i];
      byp_data_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (re_i) begin
      byp_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_q ? byp_data_q : rd_q;

endmodule

// ===== src/csem_color_match.sv =====
// ----------------------------------------------------------------------------
// csem_color_match
// Per-channel absolute difference against the seed color and tolerance test.
// ----------------------------------------------------------------------------
module csem_color_match (
  input  logic [csem_pkg::ChanW-1:0] red_i,
  input  logic [csem_pkg::ChanW-1:0] green_i,
  input  logic [csem_pkg::ChanW-1:0] blue_i,
  input  csem_pkg::csem_seed_t       seed_i,
  input  logic [csem_pkg::ChanW-1:0] tol_i,
  output logic                       match_o
);
  import csem_pkg::*;

  function automatic logic close(input logic [ChanW-1:0] a,
                                 input logic [ChanW-1:0] b,
                                 input logic [ChanW-1:0] tol);
    logic [ChanW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d <= tol;
  endfunction

  assign match_o = close(red_i, seed_i.red, tol_i) &&
                   close(green_i, seed_i.green, tol_i) &&
                   close(blue_i, seed_i.blue, tol_i);

endmodule

// ===== src/csem_window_eval.sv =====
// ----------------------------------------------------------------------------
// csem_window_eval
// Border-masked neighbor count and edge flag of a 3x3 similarity window.
// ----------------------------------------------------------------------------
module csem_window_eval (
  input  logic [csem_pkg::WinW-1:0] win_i,
  input  csem_pkg::csem_border_t    border_i,
  output csem_pkg::csem_result_t    result_o
);
  import csem_pkg::*;

  always_comb begin
    logic [CountW-1:0] cnt;
    logic              keep;
    logic              center;
    cnt    = '0;
    center = win_i[4];
    // bit index = 3 * column + row, row 0 on top, column 0 on the left
    for (int dj = 0; dj < 3; dj++) begin
      for (int di = 0; di < 3; di++) begin
        keep = !(di == 1 && dj == 1);
        if (di == 0 && border_i.top)    keep = 1'b0;
        if (di == 2 && border_i.bottom) keep = 1'b0;
        if (dj == 0 && border_i.left)   keep = 1'b0;
        if (dj == 2 && border_i.right)  keep = 1'b0;
        if (keep && win_i[3*dj+di]) begin
          cnt = cnt + CountW'(1);
        end
      end
    end
    result_o.similar   = center;
    result_o.count     = center ? cnt : '0;
    result_o.edge_flag = center && (cnt != FullCount);
  end

endmodule

// ===== src/color_similarity_edge_mask_core.sv =====
// ----------------------------------------------------------------------------
// color_similarity_edge_mask_core
// Streaming color similarity mask with 3x3 boundary detection.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled. A request is
// held in the s1 stage while the line memory read completes; when it advances the similarity bits of
// the two rows above are updated in place (read-modify-write of one two-bit
// word per column, write-first bypass for back-to-back hits) and the 3x3
// window shifts. The result for a pixel is loaded into the output register
// when the request image_width+1 positions later leaves the s1 stage.
// No clearing pass follows reset.
module color_similarity_edge_mask_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [csem_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [csem_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          in_action_i,
  input  logic [csem_pkg::ChanW-1:0]    in_pixel_red_i,
  input  logic [csem_pkg::ChanW-1:0]    in_pixel_green_i,
  input  logic [csem_pkg::ChanW-1:0]    in_pixel_blue_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [csem_pkg::ColW-1:0]     out_column_o,
  output logic [csem_pkg::RowW-1:0]     out_row_o,
  output logic                          out_is_similar_o,
  output logic                          out_is_edge_o,
  output logic [csem_pkg::CountW-1:0]   out_similar_neighbors_o
);
  import csem_pkg::*;
  `include "color_similarity_edge_mask_core_defines.svh"

  logic [ColW-1:0]   w_last_q, w_last_d;
  logic [RowW-1:0]   h_last_q, h_last_d;
  csem_seed_t        seed_q, seed_d;
  logic [ChanW-1:0]  tol_q, tol_d;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_pre_q, s1_pre_d;
  logic [ColW-1:0]   in_col_q, in_col_d;
  logic [InRowW-1:0] in_row_q, in_row_d;
  logic [ColW-1:0]   out_col_q, out_col_d;
  logic [RowW-1:0]   out_row_q, out_row_d;
  logic [WinW-1:0]   window_q, window_d;

  logic              out_valid_q, out_valid_d;
  logic [ColW-1:0]   res_col_q, res_col_d;
  logic [RowW-1:0]   res_row_q, res_row_d;
  csem_result_t      res_q, res_d;

  logic              in_acc;
  logic              s1_adv;
  logic              match;
  logic              sim;
  logic              emit;
  logic              col_wrap;
  logic              out_col_wrap;
  logic              frame_done;
  logic              dim_write;
  logic [LineW-1:0]  line_rd;
  csem_border_t      border;
  csem_result_t      eval;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  csem_color_match u_match (
    .red_i   (in_pixel_red_i),
    .green_i (in_pixel_green_i),
    .blue_i  (in_pixel_blue_i),
    .seed_i  (seed_q),
    .tol_i   (tol_q),
    .match_o (match)
  );

  csem_line_ram #(
    .Depth (MaxWidth),
    .Width (LineW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (s1_adv),
    .waddr_i (in_col_q),
    .wdata_i ({sim, line_rd[1]}),
    .re_i    (in_acc),
    .raddr_i (in_col_d),
    .rdata_o (line_rd)
  );

  assign sim          = s1_pre_q && (in_row_q <= InRowW'(h_last_q));
  assign col_wrap     = (in_col_q == w_last_q);
  assign emit         = (in_row_q > InRowW'(1)) ||
                        ((in_row_q == InRowW'(1)) && (in_col_q != '0));
  assign out_col_wrap = (out_col_q == w_last_q);
  assign frame_done   = out_col_wrap && (out_row_q == h_last_q);

  assign border.top    = (out_row_q == '0);
  assign border.bottom = (out_row_q == h_last_q);
  assign border.left   = (out_col_q == '0);
  assign border.right  = out_col_wrap;

  csem_window_eval u_eval (
    .win_i    (window_d),
    .border_i (border),
    .result_o (eval)
  );

  always_comb begin
    w_last_d  = w_last_q;
    h_last_d  = h_last_q;
    seed_d    = seed_q;
    tol_d     = tol_q;
    dim_write = 1'b0;
    if (cfg_we_i) begin
      unique case (csem_cfg_e'(cfg_index_i))
        CfgImageWidth: begin
          w_last_d  = ColW'(dim_last(cfg_data_i, DimW'(MaxWidth)));
          dim_write = 1'b1;
        end
        CfgImageHeight: begin
          h_last_d  = RowW'(dim_last(cfg_data_i, DimW'(MaxHeight)));
          dim_write = 1'b1;
        end
        CfgSeedRed:   seed_d.red   = cfg_data_i[ChanW-1:0];
        CfgSeedGreen: seed_d.green = cfg_data_i[ChanW-1:0];
        CfgSeedBlue:  seed_d.blue  = cfg_data_i[ChanW-1:0];
        CfgTolerance: tol_d        = cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_pre_d    = s1_pre_q;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    window_d    = {sim, line_rd[1], line_rd[0], window_q[WinW-1:3]};
    out_valid_d = out_valid_q;
    res_col_d   = res_col_q;
    res_row_d   = res_row_q;
    res_d       = res_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (s1_adv) begin
      s1_valid_d = 1'b0;
      if (col_wrap) begin
        in_col_d = '0;
        in_row_d = in_row_q + InRowW'(1);
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
      if (emit) begin
        out_valid_d = 1'b1;
        res_col_d   = out_col_q;
        res_row_d   = out_row_q;
        res_d       = eval;
        if (out_col_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_q + RowW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
        if (frame_done) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end
      end
    end

    if (in_acc) begin
      s1_valid_d = 1'b1;
      s1_pre_d   = match && (in_action_i == ActPixel);
    end

    if (dim_write) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q    <= ColW'(ResetWidth - DimW'(1));
      h_last_q    <= RowW'(ResetHeight - DimW'(1));
      seed_q      <= '0;
      tol_q       <= ResetTol;
      s1_valid_q  <= 1'b0;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      window_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      w_last_q    <= w_last_d;
      h_last_q    <= h_last_d;
      seed_q      <= seed_d;
      tol_q       <= tol_d;
      s1_valid_q  <= s1_valid_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      window_q    <= s1_adv ? window_d : window_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pre_q  <= s1_pre_d;
    res_col_q <= res_col_d;
    res_row_q <= res_row_d;
    res_q     <= res_d;
  end

  assign out_valid_o             = out_valid_q;
  assign out_column_o            = res_col_q;
  assign out_row_o               = res_row_q;
  assign out_is_similar_o        = res_q.similar;
  assign out_is_edge_o           = res_q.edge_flag;
  assign out_similar_neighbors_o = res_q.count;

  `CSEM_ASSERT_SAME(a_col_in_frame, out_valid_o, out_column_o <= w_last_q)
  `CSEM_ASSERT_SAME(a_flags_need_sim, out_valid_o && (out_is_edge_o || out_similar_neighbors_o != '0), out_is_similar_o)
  `CSEM_ASSERT_SAME(a_stall_when_full, in_stall_o, s1_valid_q && out_valid_q)
  `CSEM_ASSERT_NEXT(a_frame_restart, s1_adv && emit && frame_done, in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0)

endmodule
